[rtl/rgcm_pkg.sv]
// shared types, constants and the cost table of the rotated grid cost merge
package rgcm_pkg;

  // default sizes of the semantic grid
  localparam int unsigned GRID_ENTRIES_DEF = 65536;
  localparam int unsigned GRID_DIM_MAX_DEF = 256;

  // width of a linear grid address before the modulo (511 * 511 + 510 fits)
  localparam int unsigned ADDR_VAL_W = 18;

  // depth of the queue between front and back
  localparam int unsigned FIFO_DEPTH = 4;

  // accept edge to result strobe edge, no stall
  localparam int unsigned PIPE_LATENCY = 13;

  // cost codes
  localparam logic [7:0] COST_LETHAL  = 8'd254;
  localparam logic [7:0] COST_UNKNOWN = 8'd255;
  localparam int         CLASS_FULL   = 100;

  // configuration register indexes
  typedef enum logic [2:0] {
    REG_LAYER_EN   = 3'd0,
    REG_OFFSET_X   = 3'd1,
    REG_OFFSET_Y   = 3'd2,
    REG_COS_YAW    = 3'd3,
    REG_SIN_YAW    = 3'd4,
    REG_INV_RES    = 3'd5,
    REG_GRID_WIDTH = 3'd6,
    REG_GRID_HEIGHT = 3'd7
  } cfg_reg_e;

  // item opcodes
  typedef enum logic {
    OP_LOAD = 1'b0,
    OP_CELL = 1'b1
  } opcode_e;

  // configuration register set
  typedef struct packed {
    logic               layer_enabled;
    logic signed [31:0] offset_x;
    logic signed [31:0] offset_y;
    logic signed [15:0] cos_yaw;
    logic signed [15:0] sin_yaw;
    logic [24:0]        inv_resolution;
    logic [8:0]         grid_width;
    logic [8:0]         grid_height;
  } cfg_t;

  // payload carried along the front pipeline
  typedef struct packed {
    logic        is_load;
    logic [15:0] load_addr;
    logic [7:0]  load_value;
    logic [7:0]  old_cost;
    logic [15:0] col;
    logic [15:0] row;
  } pay_t;

  // classified item handed from front to back
  typedef struct packed {
    logic        is_load;
    logic        hit;
    logic [7:0]  load_value;
    logic [7:0]  old_cost;
    logic [15:0] col;
    logic [15:0] row;
  } item_t;

  // cost of a semantic class, indexed by the low seven bits of a positive entry
  typedef logic [7:0] cost_lut_t [128];

  function automatic cost_lut_t build_cost_lut();
    cost_lut_t lut;
    for (int i = 0; i < 128; i++) begin
      if (i < CLASS_FULL) begin
        lut[i] = 8'((i * int'(COST_LETHAL)) / CLASS_FULL);
      end else begin
        lut[i] = COST_LETHAL;
      end
    end
    return lut;
  endfunction

  localparam cost_lut_t COST_LUT = build_cost_lut();

endpackage

[rtl/rgcm_fifo.sv]
// short queue between the front and back of the cost merge
module rgcm_fifo import rgcm_pkg::*; #(
  parameter int unsigned W     = 8,
  parameter int unsigned DEPTH = FIFO_DEPTH
) (
  input  logic         clk_i,
  input  logic         rst_ni,
  input  logic         push_i,
  input  logic [W-1:0] wr_data_i,
  input  logic         pop_i,
  output logic [W-1:0] rd_data_o,
  output logic         empty_o,
  output logic         full_o
);

  localparam int unsigned PW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CW = $clog2(DEPTH + 1);

  logic [W-1:0]  mem_q [DEPTH];
  logic [PW-1:0] wr_ptr_q, rd_ptr_q;
  logic [CW-1:0] count_q;
  logic          do_push, do_pop;

  assign empty_o   = (count_q == '0);
  assign full_o    = (count_q == CW'(DEPTH));
  assign do_push   = push_i && !full_o;
  assign do_pop    = pop_i && !empty_o;
  assign rd_data_o = mem_q[rd_ptr_q];

  // storage
  always_ff @(posedge clk_i) begin
    if (do_push) begin
      mem_q[wr_ptr_q] <= wr_data_i;
    end
  end

  // pointers and fill count
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      count_q  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_q <= (wr_ptr_q == PW'(DEPTH - 1)) ? '0 : wr_ptr_q + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_q <= (rd_ptr_q == PW'(DEPTH - 1)) ? '0 : rd_ptr_q + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_q <= count_q + 1'b1;
      end else if (do_pop && !do_push) begin
        count_q <= count_q - 1'b1;
      end
    end
  end

endmodule

[rtl/rgcm_front.sv]
// front part: accepts items, transforms cell positions and forms the grid address
module rgcm_front import rgcm_pkg::*; #(
  parameter int unsigned GRID_ENTRIES = GRID_ENTRIES_DEF,
  parameter int unsigned GRID_DIM_MAX = GRID_DIM_MAX_DEF
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  cfg_t                              cfg_i,
  input  logic                              start_i,
  input  logic                              opcode_i,
  input  logic [15:0]                       load_addr_i,
  input  logic signed [7:0]                 load_value_i,
  input  logic signed [31:0]                world_x_i,
  input  logic signed [31:0]                world_y_i,
  input  logic [7:0]                        old_cost_i,
  input  logic [15:0]                       cell_col_i,
  input  logic [15:0]                       cell_row_i,
  input  logic                              stall_i,
  output logic                              push_o,
  output item_t                             push_item_o,
  output logic [$clog2(GRID_ENTRIES)-1:0]   push_addr_o
);

  localparam int unsigned AW     = $clog2(GRID_ENTRIES);
  localparam int unsigned VW     = ADDR_VAL_W;
  localparam int unsigned ENT_W  = $clog2(GRID_ENTRIES + 1);
  localparam int unsigned NSTAGE = 10;
  localparam longint unsigned RECIP_L = (64'd1 << VW) / GRID_ENTRIES;
  localparam logic [VW:0] RECIP = (VW + 1)'(RECIP_L);

  logic adv;

  // stage valid bits and carried payload
  logic [NSTAGE-1:0] vld_q;
  pay_t              pay_q [NSTAGE];

  // datapath registers per stage
  logic signed [31:0] wx_q, wy_q;
  logic signed [47:0] pcx_q, psy_q, psx_q, pcy_q;
  logic signed [48:0] mx_q, my_q;
  logic               nx4_q, ny4_q, nx5_q, ny5_q, nx6_q, ny6_q;
  logic [47:0]        ax_q, ay_q;
  logic [48:0]        xh_q, xl_q, yh_q, yl_q;
  logic [26:0]        qx_q, qy_q;
  logic [8:0]         gx_q, gy_q;
  logic               hit7_q, hit8_q, hit9_q, hit10_q;
  logic [VW-1:0]      val8_q, val9_q, val10_q, qe_q, prod_q;

  // combinational next values
  logic signed [48:0] mx_d, my_d;
  logic [47:0]        ax_d, ay_d;
  logic [72:0]        fx_d, fy_d;
  logic [8:0]         w_sat, h_sat;
  logic               inx_d, iny_d;
  logic [VW-1:0]      val_d;
  logic [2*VW:0]      qp_d;
  logic [VW+ENT_W-1:0] pm_d;
  logic [VW-1:0]      rem_d, addr_d;

  assign adv = !stall_i;

  // dimensions clamped to the largest grid
  assign w_sat = (32'(cfg_i.grid_width) > GRID_DIM_MAX) ? 9'(GRID_DIM_MAX)
                                                         : cfg_i.grid_width;
  assign h_sat = (32'(cfg_i.grid_height) > GRID_DIM_MAX) ? 9'(GRID_DIM_MAX)
                                                          : cfg_i.grid_height;

  // rotation sums and magnitudes
  always_comb begin
    mx_d = (49'(cfg_i.offset_x) <<< 14) + 49'(pcx_q) - 49'(psy_q);
    my_d = (49'(cfg_i.offset_y) <<< 14) + 49'(psx_q) + 49'(pcy_q);
    ax_d = mx_q[48] ? 48'(-mx_q) : mx_q[47:0];
    ay_d = my_q[48] ? 48'(-my_q) : my_q[47:0];
  end

  // scaled index and bounds check
  always_comb begin
    fx_d  = {xh_q, 24'd0} + 73'(xl_q);
    fy_d  = {yh_q, 24'd0} + 73'(yl_q);
    inx_d = (!nx6_q || qx_q == '0) && (qx_q < 27'(w_sat));
    iny_d = (!ny6_q || qy_q == '0) && (qy_q < 27'(h_sat));
  end

  // linear address and its remainder by the store size
  always_comb begin
    if (pay_q[6].is_load) begin
      val_d = VW'(pay_q[6].load_addr);
    end else begin
      val_d = VW'(VW'(gy_q) * VW'(w_sat)) + VW'(gx_q);
    end
    qp_d  = (2 * VW + 1)'(val8_q) * (2 * VW + 1)'(RECIP);
    pm_d  = (VW + ENT_W)'(qe_q) * (VW + ENT_W)'(GRID_ENTRIES);
    rem_d = val10_q - prod_q;
    if (32'(rem_d) >= GRID_ENTRIES) begin
      addr_d = rem_d - VW'(GRID_ENTRIES);
    end else begin
      addr_d = rem_d;
    end
  end

  // stage valid bits
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q <= '0;
    end else if (adv) begin
      vld_q <= {vld_q[NSTAGE-2:0], start_i};
    end
  end

  // payload and datapath stages
  always_ff @(posedge clk_i) begin
    if (adv) begin
      pay_q[0] <= '{is_load: (opcode_i == OP_LOAD), load_addr: load_addr_i,
                    load_value: load_value_i, old_cost: old_cost_i,
                    col: cell_col_i, row: cell_row_i};
      for (int k = 1; k < NSTAGE; k++) begin
        pay_q[k] <= pay_q[k-1];
      end
      // capture position
      wx_q    <= world_x_i;
      wy_q    <= world_y_i;
      // rotation products
      pcx_q   <= 48'(cfg_i.cos_yaw) * 48'(wx_q);
      psy_q   <= 48'(cfg_i.sin_yaw) * 48'(wy_q);
      psx_q   <= 48'(cfg_i.sin_yaw) * 48'(wx_q);
      pcy_q   <= 48'(cfg_i.cos_yaw) * 48'(wy_q);
      // translated position
      mx_q    <= mx_d;
      my_q    <= my_d;
      // sign and magnitude
      nx4_q   <= mx_q[48];
      ny4_q   <= my_q[48];
      ax_q    <= ax_d;
      ay_q    <= ay_d;
      // partial products of the scaling
      nx5_q   <= nx4_q;
      ny5_q   <= ny4_q;
      xh_q    <= 49'(ax_q[47:24]) * 49'(cfg_i.inv_resolution);
      xl_q    <= 49'(ax_q[23:0]) * 49'(cfg_i.inv_resolution);
      yh_q    <= 49'(ay_q[47:24]) * 49'(cfg_i.inv_resolution);
      yl_q    <= 49'(ay_q[23:0]) * 49'(cfg_i.inv_resolution);
      // truncated index magnitude
      nx6_q   <= nx5_q;
      ny6_q   <= ny5_q;
      qx_q    <= fx_d[72:46];
      qy_q    <= fy_d[72:46];
      // classification
      gx_q    <= qx_q[8:0];
      gy_q    <= qy_q[8:0];
      hit7_q  <= inx_d && iny_d;
      // linear address
      val8_q  <= val_d;
      hit8_q  <= hit7_q;
      // quotient estimate
      qe_q    <= qp_d[2*VW-1:VW];
      val9_q  <= val8_q;
      hit9_q  <= hit8_q;
      // quotient times store size
      prod_q  <= pm_d[VW-1:0];
      val10_q <= val9_q;
      hit10_q <= hit9_q;
    end
  end

  // hand over to the queue
  assign push_o      = vld_q[NSTAGE-1] && adv;
  assign push_addr_o = AW'(addr_d);
  assign push_item_o = '{is_load: pay_q[NSTAGE-1].is_load, hit: hit10_q,
                         load_value: pay_q[NSTAGE-1].load_value,
                         old_cost: pay_q[NSTAGE-1].old_cost,
                         col: pay_q[NSTAGE-1].col, row: pay_q[NSTAGE-1].row};

endmodule

[rtl/rgcm_back.sv]
// back part: semantic store, lookup and cost merge
module rgcm_back import rgcm_pkg::*; #(
  parameter int unsigned GRID_ENTRIES = GRID_ENTRIES_DEF
) (
  input  logic                            clk_i,
  input  logic                            rst_ni,
  input  logic                            layer_enabled_i,
  input  logic                            valid_i,
  input  item_t                           item_i,
  input  logic [$clog2(GRID_ENTRIES)-1:0] addr_i,
  output logic                            result_valid_o,
  output logic [15:0]                     out_col_o,
  output logic [15:0]                     out_row_o,
  output logic [7:0]                      new_cost_o,
  output logic                            write_enable_o
);

  logic [7:0]        mem [GRID_ENTRIES];
  logic [7:0]        rd_q;
  logic              vld_q, loaded_q;
  item_t             item_q;
  logic              res_vld_q, we_q;
  logic [15:0]       col_q, row_q;
  logic [7:0]        cost_q;

  logic signed [7:0] ent;
  logic [7:0]        cls_cost;
  logic              take_d;
  logic [7:0]        cost_d;

  // store write for load items
  always_ff @(posedge clk_i) begin
    if (valid_i && item_i.is_load) begin
      mem[addr_i] <= item_i.load_value;
    end
  end

  // registered lookup
  always_ff @(posedge clk_i) begin
    rd_q <= mem[addr_i];
  end

  // lookup stage control
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= 1'b0;
      loaded_q <= 1'b0;
    end else begin
      vld_q <= valid_i;
      if (valid_i && item_i.is_load) begin
        loaded_q <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    item_q <= item_i;
  end

  // cost mapping and merge decision
  always_comb begin
    ent      = $signed(rd_q);
    cls_cost = (ent >= 8'sd100) ? COST_LETHAL : COST_LUT[rd_q[6:0]];
    take_d   = layer_enabled_i && loaded_q && item_q.hit && (ent > 8'sd0) &&
               ((item_q.old_cost == COST_UNKNOWN) || (item_q.old_cost < cls_cost));
    cost_d   = take_d ? cls_cost : item_q.old_cost;
  end

  // result strobe
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      res_vld_q <= 1'b0;
      we_q      <= 1'b0;
    end else begin
      res_vld_q <= vld_q && !item_q.is_load;
      we_q      <= vld_q && !item_q.is_load && take_d;
    end
  end

  // result payload
  always_ff @(posedge clk_i) begin
    col_q  <= item_q.col;
    row_q  <= item_q.row;
    cost_q <= cost_d;
  end

  assign result_valid_o = res_vld_q;
  assign write_enable_o = we_q;
  assign out_col_o      = col_q;
  assign out_row_o      = row_q;
  assign new_cost_o     = cost_q;

endmodule

[rtl/rotated_grid_cost_merge.sv]
// top level of the rotated grid cost merge
// One item is taken per clock cycle. A cell item passes through the front pipeline of rotation
// multipliers, split scaling multipliers and the address remainder unit, then through the queue
// to the back part, which adds the store read and the merge. Load items give no result. The
// result stands for one cycle under result_valid_o; the receiver cannot hold it off. busy_o
// rises only when the queue between front and back is full, and as the back part drains one
// entry every cycle it stays low. The semantic store needs no clearing after reset, so items
// are accepted at once.
module rotated_grid_cost_merge import rgcm_pkg::*; #(
  parameter int unsigned GRID_ENTRIES = GRID_ENTRIES_DEF,
  parameter int unsigned GRID_DIM_MAX = GRID_DIM_MAX_DEF
) (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start_i,
  output logic               busy_o,
  input  logic               opcode_i,
  input  logic [15:0]        load_addr_i,
  input  logic signed [7:0]  load_value_i,
  input  logic signed [31:0] world_x_i,
  input  logic signed [31:0] world_y_i,
  input  logic [7:0]         old_cost_i,
  input  logic [15:0]        cell_col_i,
  input  logic [15:0]        cell_row_i,
  output logic               result_valid_o,
  output logic [15:0]        out_col_o,
  output logic [15:0]        out_row_o,
  output logic [7:0]         new_cost_o,
  output logic               write_enable_o
);

  localparam int unsigned AW = $clog2(GRID_ENTRIES);
  localparam int unsigned QW = $bits(item_t) + AW;

  cfg_t          cfg_q;
  logic          push, fifo_full, fifo_empty;
  item_t         push_item, pop_item;
  logic [AW-1:0] push_addr, pop_addr;
  logic [QW-1:0] pop_data;

  // configuration registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cfg_q.layer_enabled  <= 1'b1;
      cfg_q.offset_x       <= '0;
      cfg_q.offset_y       <= '0;
      cfg_q.cos_yaw        <= 16'sd16384;
      cfg_q.sin_yaw        <= '0;
      cfg_q.inv_resolution <= 25'd1310720;
      cfg_q.grid_width     <= 9'd256;
      cfg_q.grid_height    <= 9'd256;
    end else if (cfg_we_i) begin
      case (cfg_reg_e'(cfg_addr_i))
        REG_LAYER_EN:    cfg_q.layer_enabled  <= cfg_wdata_i[0];
        REG_OFFSET_X:    cfg_q.offset_x       <= cfg_wdata_i;
        REG_OFFSET_Y:    cfg_q.offset_y       <= cfg_wdata_i;
        REG_COS_YAW:     cfg_q.cos_yaw        <= cfg_wdata_i[15:0];
        REG_SIN_YAW:     cfg_q.sin_yaw        <= cfg_wdata_i[15:0];
        REG_INV_RES:     cfg_q.inv_resolution <= cfg_wdata_i[24:0];
        REG_GRID_WIDTH:  cfg_q.grid_width     <= cfg_wdata_i[8:0];
        REG_GRID_HEIGHT: cfg_q.grid_height    <= cfg_wdata_i[8:0];
        default: ;
      endcase
    end
  end

  assign busy_o = fifo_full;

  // transform and classify
  rgcm_front #(
    .GRID_ENTRIES (GRID_ENTRIES),
    .GRID_DIM_MAX (GRID_DIM_MAX)
  ) u_front (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_i        (cfg_q),
    .start_i      (start_i),
    .opcode_i     (opcode_i),
    .load_addr_i  (load_addr_i),
    .load_value_i (load_value_i),
    .world_x_i    (world_x_i),
    .world_y_i    (world_y_i),
    .old_cost_i   (old_cost_i),
    .cell_col_i   (cell_col_i),
    .cell_row_i   (cell_row_i),
    .stall_i      (fifo_full),
    .push_o       (push),
    .push_item_o  (push_item),
    .push_addr_o  (push_addr)
  );

  // queue between front and back
  rgcm_fifo #(
    .W     (QW),
    .DEPTH (FIFO_DEPTH)
  ) u_fifo (
    .clk_i     (clk_i),
    .rst_ni    (rst_ni),
    .push_i    (push),
    .wr_data_i ({push_addr, push_item}),
    .pop_i     (!fifo_empty),
    .rd_data_o (pop_data),
    .empty_o   (fifo_empty),
    .full_o    (fifo_full)
  );

  assign {pop_addr, pop_item} = pop_data;

  // store lookup and merge
  rgcm_back #(
    .GRID_ENTRIES (GRID_ENTRIES)
  ) u_back (
    .clk_i           (clk_i),
    .rst_ni          (rst_ni),
    .layer_enabled_i (cfg_q.layer_enabled),
    .valid_i         (!fifo_empty),
    .item_i          (pop_item),
    .addr_i          (pop_addr),
    .result_valid_o  (result_valid_o),
    .out_col_o       (out_col_o),
    .out_row_o       (out_row_o),
    .new_cost_o      (new_cost_o),
    .write_enable_o  (write_enable_o)
  );

endmodule

[rtl/rgcm_checker.sv]
// port-level checks of the rotated grid cost merge, bound to the top level
module rgcm_checker import rgcm_pkg::*; (
  input logic       clk_i,
  input logic       rst_ni,
  input logic       start_i,
  input logic       busy_o,
  input logic       opcode_i,
  input logic       result_valid_o,
  input logic [7:0] new_cost_o,
  input logic       write_enable_o
);

  // a cost write only comes with a result transfer
  a_we_with_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> result_valid_o)
    else $error("cost write without result strobe");

  // a written cost is never the unknown code
  a_we_cost_known: assert property (@(posedge clk_i) disable iff (!rst_ni)
    write_enable_o |-> (new_cost_o != COST_UNKNOWN))
    else $error("written cost is unknown");

  // every result traces back to a cell item accepted a fixed time earlier
  a_result_latency: assert property (@(posedge clk_i) disable iff (!rst_ni)
    result_valid_o |-> $past(start_i && !busy_o && (opcode_i == OP_CELL), PIPE_LATENCY))
    else $error("result without matching cell item");

  // the back part drains the queue every cycle, so the front never stalls
  a_never_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    !busy_o)
    else $error("front stalled by full queue");

endmodule

bind rotated_grid_cost_merge rgcm_checker u_checker (.*);

[test/rgcm_cost_monitor.sv]
// transfer monitor, cost predictor and result comparison for the rotated grid cost merge
module rgcm_cost_monitor import rgcm_pkg::*; (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               cfg_we_i,
  input  logic [2:0]         cfg_addr_i,
  input  logic [31:0]        cfg_wdata_i,
  input  logic               start_i,
  input  logic               busy_i,
  input  logic               opcode_i,
  input  logic [15:0]        load_addr_i,
  input  logic signed [7:0]  load_value_i,
  input  logic signed [31:0] world_x_i,
  input  logic signed [31:0] world_y_i,
  input  logic [7:0]         old_cost_i,
  input  logic [15:0]        cell_col_i,
  input  logic [15:0]        cell_row_i,
  input  logic               result_valid_i,
  input  logic [15:0]        out_col_i,
  input  logic [15:0]        out_row_i,
  input  logic [7:0]         new_cost_i,
  input  logic               write_enable_i,
  output int                 fail_count_o,
  output int                 pending_o,
  output int                 results_o,
  output int                 writes_o
);
  timeunit 1ns;
  timeprecision 1ps;

  typedef struct packed {
    logic [15:0] col;
    logic [15:0] row;
    logic [7:0]  cost;
    logic        we;
  } cost_update_t;

  // own copy of the register set and the semantic grid
  logic               layer_en;
  logic signed [31:0] offs_x;
  logic signed [31:0] offs_y;
  logic signed [15:0] cos_q14;
  logic signed [15:0] sin_q14;
  logic [24:0]        cells_per_m;
  logic [8:0]         grid_w;
  logic [8:0]         grid_h;
  logic               grid_loaded;
  logic signed [7:0]  sem_grid [GRID_ENTRIES_DEF];

  cost_update_t expected_updates [$];
  int fails;
  int results_seen;
  int writes_seen;

  // truncated grid index of a Q.30 position, -1 when it falls below zero
  function automatic longint grid_index(longint pos, logic [24:0] scale);
    logic [47:0] mag;
    logic [72:0] prod;
    logic [26:0] q;
    mag  = (pos < 0) ? 48'(-pos) : 48'(pos);
    prod = 73'(mag) * 73'(scale);
    q    = 27'(prod >> 46);
    if (pos < 0 && q != 0) return -1;
    return longint'(q);
  endfunction

  // rotate, translate, scale, look up and merge one cell
  function automatic cost_update_t predict_cell(logic signed [31:0] wx, logic signed [31:0] wy,
                                                logic [7:0] old, logic [15:0] col,
                                                logic [15:0] row);
    cost_update_t r;
    longint px, py, ix, iy;
    longint w, h;
    logic [15:0] addr;
    int v;
    int c;
    r.col  = col;
    r.row  = row;
    r.cost = old;
    r.we   = 1'b0;
    if (layer_en && grid_loaded) begin
      w  = (grid_w > GRID_DIM_MAX_DEF) ? longint'(GRID_DIM_MAX_DEF) : longint'(grid_w);
      h  = (grid_h > GRID_DIM_MAX_DEF) ? longint'(GRID_DIM_MAX_DEF) : longint'(grid_h);
      px = longint'(offs_x) * 16384 + longint'(cos_q14) * longint'(wx)
           - longint'(sin_q14) * longint'(wy);
      py = longint'(offs_y) * 16384 + longint'(sin_q14) * longint'(wx)
           + longint'(cos_q14) * longint'(wy);
      ix = grid_index(px, cells_per_m);
      iy = grid_index(py, cells_per_m);
      if (ix >= 0 && iy >= 0 && ix < w && iy < h) begin
        addr = 16'((iy * w + ix) % longint'(GRID_ENTRIES_DEF));
        v    = sem_grid[addr];
        if (v > 0) begin
          c = (v >= CLASS_FULL) ? int'(COST_LETHAL) : (v * int'(COST_LETHAL)) / CLASS_FULL;
          if (old == COST_UNKNOWN || int'(old) < c) begin
            r.cost = 8'(c);
            r.we   = 1'b1;
          end
        end
      end
    end
    return r;
  endfunction

  always @(posedge clk_i or negedge rst_ni) begin
    cost_update_t exp_upd;
    if (!rst_ni) begin
      layer_en     = 1'b1;
      offs_x       = '0;
      offs_y       = '0;
      cos_q14      = 16'sd16384;
      sin_q14      = '0;
      cells_per_m  = 25'd1310720;
      grid_w       = 9'd256;
      grid_h       = 9'd256;
      grid_loaded  = 1'b0;
      fails        = 0;
      results_seen = 0;
      writes_seen  = 0;
      expected_updates.delete();
      fail_count_o <= 0;
      pending_o    <= 0;
      results_o    <= 0;
      writes_o     <= 0;
    end else begin
      // register writes
      if (cfg_we_i) begin
        case (cfg_reg_e'(cfg_addr_i))
          REG_LAYER_EN:    layer_en    = cfg_wdata_i[0];
          REG_OFFSET_X:    offs_x      = cfg_wdata_i;
          REG_OFFSET_Y:    offs_y      = cfg_wdata_i;
          REG_COS_YAW:     cos_q14     = cfg_wdata_i[15:0];
          REG_SIN_YAW:     sin_q14     = cfg_wdata_i[15:0];
          REG_INV_RES:     cells_per_m = cfg_wdata_i[24:0];
          REG_GRID_WIDTH:  grid_w      = cfg_wdata_i[8:0];
          REG_GRID_HEIGHT: grid_h      = cfg_wdata_i[8:0];
          default: ;
        endcase
      end

      // result transfer against the oldest expectation
      if (result_valid_i) begin
        results_seen++;
        if (write_enable_i === 1'b1) writes_seen++;
        if (expected_updates.size() == 0) begin
          $error("result with nothing expected: col %0d row %0d cost %0d we %0b",
                 out_col_i, out_row_i, new_cost_i, write_enable_i);
          fails++;
        end else begin
          exp_upd = expected_updates.pop_front();
          if (out_col_i !== exp_upd.col) begin
            $error("out_col expected %0d, got %0d", exp_upd.col, out_col_i);
            fails++;
          end
          if (out_row_i !== exp_upd.row) begin
            $error("out_row expected %0d, got %0d", exp_upd.row, out_row_i);
            fails++;
          end
          if (new_cost_i !== exp_upd.cost) begin
            $error("new_cost expected %0d, got %0d", exp_upd.cost, new_cost_i);
            fails++;
          end
          if (write_enable_i !== exp_upd.we) begin
            $error("write_enable expected %0b, got %0b", exp_upd.we, write_enable_i);
            fails++;
          end
        end
      end

      // input transfer: loads fill the grid, cells queue their predicted update
      if (start_i && !busy_i) begin
        if (opcode_i == OP_LOAD) begin
          sem_grid[load_addr_i] = load_value_i;
          grid_loaded           = 1'b1;
        end else begin
          expected_updates.push_back(predict_cell(world_x_i, world_y_i, old_cost_i,
                                                  cell_col_i, cell_row_i));
        end
      end

      fail_count_o <= fails;
      pending_o    <= expected_updates.size();
      results_o    <= results_seen;
      writes_o     <= writes_seen;
    end
  end

endmodule

[test/tb_rotated_grid_cost_merge.sv]
// stimulus and verdict for the rotated grid cost merge
module tb_rotated_grid_cost_merge import rgcm_pkg::*;;
  timeunit 1ns;
  timeprecision 1ps;

  logic               clk_i          = 1'b0;
  logic               rst_ni         = 1'b0;
  logic               cfg_we_i       = 1'b0;
  logic [2:0]         cfg_addr_i     = REG_LAYER_EN;
  logic [31:0]        cfg_wdata_i    = '0;
  logic               start_i        = 1'b0;
  logic               opcode_i       = OP_LOAD;
  logic [15:0]        load_addr_i    = '0;
  logic signed [7:0]  load_value_i   = '0;
  logic signed [31:0] world_x_i      = '0;
  logic signed [31:0] world_y_i      = '0;
  logic [7:0]         old_cost_i     = '0;
  logic [15:0]        cell_col_i     = '0;
  logic [15:0]        cell_row_i     = '0;
  logic               busy_o;
  logic               result_valid_o;
  logic [15:0]        out_col_o;
  logic [15:0]        out_row_o;
  logic [7:0]         new_cost_o;
  logic               write_enable_o;

  int fail_count;
  int pending;
  int results_seen;
  int writes_seen;

  // settings currently held by the block, used to aim cells at the grid
  logic               cur_en;
  logic signed [31:0] cur_offx;
  logic signed [31:0] cur_offy;
  logic signed [15:0] cur_cos;
  logic signed [15:0] cur_sin;
  logic [24:0]        cur_inv;
  logic [8:0]         cur_w;
  logic [8:0]         cur_h;

  int loads_sent;
  int cells_sent;
  int settings_used;
  bit idle_on;

  // semantic classes and old costs of the small directed grid
  localparam logic [7:0] DIRECT_CLASS [16] = '{
    8'd77, 8'hFF, 8'd0, 8'd1, 8'd2, 8'd39, 8'd50, 8'd99,
    8'd100, 8'd101, 8'd127, 8'h80, 8'd10, 8'd98, 8'd3, 8'd70
  };
  localparam logic [7:0] DIRECT_OLD [16] = '{
    8'd255, 8'd255, 8'd255, 8'd255, 8'd0, 8'd255, 8'd127, 8'd250,
    8'd254, 8'd0, 8'd253, 8'd255, 8'd25, 8'd249, 8'd8, 8'd177
  };

  always #4 clk_i = ~clk_i;

  rotated_grid_cost_merge DUT (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_o         (busy_o),
    .opcode_i       (opcode_i),
    .load_addr_i    (load_addr_i),
    .load_value_i   (load_value_i),
    .world_x_i      (world_x_i),
    .world_y_i      (world_y_i),
    .old_cost_i     (old_cost_i),
    .cell_col_i     (cell_col_i),
    .cell_row_i     (cell_row_i),
    .result_valid_o (result_valid_o),
    .out_col_o      (out_col_o),
    .out_row_o      (out_row_o),
    .new_cost_o     (new_cost_o),
    .write_enable_o (write_enable_o)
  );

  rgcm_cost_monitor u_monitor (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cfg_we_i       (cfg_we_i),
    .cfg_addr_i     (cfg_addr_i),
    .cfg_wdata_i    (cfg_wdata_i),
    .start_i        (start_i),
    .busy_i         (busy_o),
    .opcode_i       (opcode_i),
    .load_addr_i    (load_addr_i),
    .load_value_i   (load_value_i),
    .world_x_i      (world_x_i),
    .world_y_i      (world_y_i),
    .old_cost_i     (old_cost_i),
    .cell_col_i     (cell_col_i),
    .cell_row_i     (cell_row_i),
    .result_valid_i (result_valid_o),
    .out_col_i      (out_col_o),
    .out_row_i      (out_row_o),
    .new_cost_i     (new_cost_o),
    .write_enable_i (write_enable_o),
    .fail_count_o   (fail_count),
    .pending_o      (pending),
    .results_o      (results_seen),
    .writes_o       (writes_seen)
  );

  function automatic logic signed [15:0] q14(real x);
    return 16'($rtoi(x * 16384.0 + ((x >= 0.0) ? 0.5 : -0.5)));
  endfunction

  function automatic logic signed [31:0] to_q16(real m);
    real x;
    x = m * 65536.0;
    if (x > 2147483647.0) x = 2147483647.0;
    if (x < -2147483648.0) x = -2147483648.0;
    return 32'($rtoi(x));
  endfunction

  function automatic int eff_dim(logic [8:0] d);
    return (d > GRID_DIM_MAX_DEF) ? int'(GRID_DIM_MAX_DEF) : int'(d);
  endfunction

  // semantic value, weighted towards the cost classes
  function automatic logic [7:0] sem_value();
    case ($urandom_range(0, 9))
      0, 1, 2, 3: return 8'($urandom_range(1, 100));
      4, 5:       return 8'($urandom_range(101, 127));
      6:          return 8'hFF;
      7:          return 8'(0 - int'($urandom_range(0, 128)));
      default:    return 8'($urandom);
    endcase
  endfunction

  // world position that lands on grid position (gx, gy) under the current settings
  task automatic aim_at(input real gx, input real gy,
                        output logic signed [31:0] wx, output logic signed [31:0] wy);
    real inv_m, px, py, cr, sr, det;
    inv_m = $itor(cur_inv) / 65536.0;
    cr    = $itor(cur_cos) / 16384.0;
    sr    = $itor(cur_sin) / 16384.0;
    det   = cr * cr + sr * sr;
    if (cur_inv == 0 || det == 0.0) begin
      wx = $urandom;
      wy = $urandom;
    end else begin
      px = gx / inv_m - $itor(cur_offx) / 65536.0;
      py = gy / inv_m - $itor(cur_offy) / 65536.0;
      wx = to_q16((cr * px + sr * py) / det);
      wy = to_q16((cr * py - sr * px) / det);
    end
  endtask

  // one input transfer; start stays high for a following item
  task automatic push_item(input logic op, input logic [15:0] addr, input logic [7:0] val,
                           input logic signed [31:0] wx, input logic signed [31:0] wy,
                           input logic [7:0] old, input logic [15:0] col,
                           input logic [15:0] row);
    start_i      <= 1'b1;
    opcode_i     <= op;
    load_addr_i  <= addr;
    load_value_i <= val;
    world_x_i    <= wx;
    world_y_i    <= wy;
    old_cost_i   <= old;
    cell_col_i   <= col;
    cell_row_i   <= row;
    do @(posedge clk_i); while (busy_o);
  endtask

  task automatic send_load(input logic [15:0] addr, input logic [7:0] val);
    push_item(OP_LOAD, addr, val, $urandom, $urandom, 8'($urandom), 16'($urandom),
              16'($urandom));
    loads_sent++;
  endtask

  task automatic send_cell(input logic signed [31:0] wx, input logic signed [31:0] wy,
                           input logic [7:0] old, input logic [15:0] col,
                           input logic [15:0] row);
    push_item(OP_CELL, 16'($urandom), 8'($urandom), wx, wy, old, col, row);
    cells_sent++;
  endtask

  task automatic send_aimed(input real gx, input real gy, input logic [7:0] old);
    logic signed [31:0] wx, wy;
    aim_at(gx, gy, wx, wy);
    send_cell(wx, wy, old, 16'($urandom), 16'($urandom));
  endtask

  // random gap before a transfer
  task automatic maybe_pause();
    if (idle_on && $urandom_range(0, 4) == 0) begin
      start_i <= 1'b0;
      repeat ($urandom_range(1, 6)) @(posedge clk_i);
    end
  endtask

  // wait until every update has come back and loads have left the pipeline
  task automatic settle();
    start_i <= 1'b0;
    do @(posedge clk_i); while (pending != 0);
    repeat (PIPE_LATENCY + 4) @(posedge clk_i);
  endtask

  task automatic put_reg(input cfg_reg_e idx, input logic [31:0] data);
    cfg_we_i    <= 1'b1;
    cfg_addr_i  <= idx;
    cfg_wdata_i <= data;
    @(posedge clk_i);
  endtask

  task automatic program_regs(input logic en, input logic signed [31:0] offx,
                              input logic signed [31:0] offy, input logic signed [15:0] cs,
                              input logic signed [15:0] sn, input logic [24:0] inv,
                              input logic [8:0] w, input logic [8:0] h);
    cur_en   = en;
    cur_offx = offx;
    cur_offy = offy;
    cur_cos  = cs;
    cur_sin  = sn;
    cur_inv  = inv;
    cur_w    = w;
    cur_h    = h;
    put_reg(REG_LAYER_EN, {31'd0, en});
    put_reg(REG_OFFSET_X, offx);
    put_reg(REG_OFFSET_Y, offy);
    put_reg(REG_COS_YAW, {{16{cs[15]}}, cs});
    put_reg(REG_SIN_YAW, {{16{sn[15]}}, sn});
    put_reg(REG_INV_RES, {7'd0, inv});
    put_reg(REG_GRID_WIDTH, {23'd0, w});
    put_reg(REG_GRID_HEIGHT, {23'd0, h});
    cfg_we_i <= 1'b0;
    settings_used++;
  endtask

  // one setting: program, load the whole area in use, then mixed traffic
  task automatic run_phase(input logic en, input logic signed [31:0] offx,
                           input logic signed [31:0] offy, input logic signed [15:0] cs,
                           input logic signed [15:0] sn, input logic [24:0] inv,
                           input logic [8:0] w, input logic [8:0] h, input int n_items,
                           input bit allow_idle);
    int area, ew, eh;
    logic signed [31:0] wx, wy;
    logic [7:0] old;
    program_regs(en, offx, offy, cs, sn, inv, w, h);
    area = eff_dim(w) * eff_dim(h);
    idle_on = allow_idle;
    for (int a = 0; a < area; a++) begin
      if (a % 48 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      maybe_pause();
      send_load(16'(a), sem_value());
    end
    ew = (eff_dim(w) == 0) ? 4 : eff_dim(w);
    eh = (eff_dim(h) == 0) ? 4 : eff_dim(h);
    for (int i = 0; i < n_items; i++) begin
      if (i % 48 == 0) idle_on = allow_idle && ($urandom_range(0, 3) != 0);
      maybe_pause();
      if ($urandom_range(0, 6) == 0) begin
        send_load(16'($urandom), 8'($urandom));
      end else begin
        // mostly cells aimed at the grid and its rim, some anywhere
        if ($urandom_range(0, 4) != 0) begin
          aim_at(($urandom_range(0, 10000) / 10000.0) * (ew + 2) - 1.0,
                 ($urandom_range(0, 10000) / 10000.0) * (eh + 2) - 1.0, wx, wy);
        end else begin
          wx = $urandom;
          wy = $urandom;
        end
        case ($urandom_range(0, 9))
          0, 1, 2: old = COST_UNKNOWN;
          3:       old = 8'd0;
          4:       old = COST_LETHAL;
          default: old = 8'($urandom);
        endcase
        send_cell(wx, wy, old, 16'($urandom), 16'($urandom));
      end
    end
    settle();
  endtask

  initial begin
    #3_000_000;
    $display("RESULT: ERROR");
    $finish;
  end

  initial begin
    loads_sent    = 0;
    cells_sent    = 0;
    settings_used = 0;
    idle_on       = 1'b0;
    cur_en        = 1'b1;
    cur_offx      = '0;
    cur_offy      = '0;
    cur_cos       = 16'sd16384;
    cur_sin       = '0;
    cur_inv       = 25'd1310720;
    cur_w         = 9'd256;
    cur_h         = 9'd256;
    repeat (7) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // no grid loaded yet: nothing may be written
    send_cell(32'sh7FFFFFFF, 32'sh80000000, COST_UNKNOWN, 16'hFFFF, 16'h0000);
    send_aimed(1.5, 1.5, COST_UNKNOWN);
    settle();

    // small 4 by 4 grid holding every class of interest
    program_regs(1'b1, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 25'd1310720, 9'd4, 9'd4);
    for (int i = 0; i < 16; i++) send_load(16'(i), DIRECT_CLASS[i]);
    for (int i = 0; i < 16; i++) send_aimed((i % 4) + 0.5, (i / 4) + 0.5, DIRECT_OLD[i]);
    // slightly negative position truncates to index 0, then just past the right and the bottom edge
    send_aimed(-0.4, -0.4, 8'd0);
    send_aimed(4.5, 1.5, COST_UNKNOWN);
    send_aimed(1.5, 4.5, COST_UNKNOWN);
    send_cell(32'sh80000000, 32'sh7FFFFFFF, 8'd0, 16'h0000, 16'hFFFF);
    settle();

    // random traffic over a range of settings, extremes included
    run_phase(1'b1, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 25'd1310720, 9'd16, 9'd16, 140, 1'b1);
    run_phase(1'b1, 32'sd19661, -32'sd13107, q14($cos(0.5236)), q14($sin(0.5236)),
              25'd1310720, 9'd24, 9'd10, 140, 1'b1);
    run_phase(1'b1, 32'sd13107, 32'sd13107, -16'sd16384, 16'sd0, 25'd1310720, 9'd1, 9'd1,
              100, 1'b1);
    run_phase(1'b1, -32'sd6554, 32'sd6554, 16'sd0, 16'sd16384, 25'd16777216, 9'd256, 9'd4,
              120, 1'b1);
    run_phase(1'b1, 32'sd196608, -32'sd458752, 16'sd0, -16'sd16384, 25'd1, 9'd2, 9'd256,
              100, 1'b1);
    // zero scale sends every position to index 0
    run_phase(1'b1, 32'sd65536, 32'sd65536, q14($cos(1.0)), q14($sin(1.0)), 25'd0, 9'd8,
              9'd8, 100, 1'b1);
    // oversized dimensions saturate
    run_phase(1'b1, 32'sd0, 32'sd0, q14($cos(-2.0)), q14($sin(-2.0)), 25'd655360, 9'd511,
              9'd2, 100, 1'b1);
    run_phase(1'b1, -32'sd32768, 32'sd98304, q14($cos(2.5)), q14($sin(2.5)), 25'd3276800,
              9'd3, 9'd300, 100, 1'b1);
    // zero width puts everything outside
    run_phase(1'b1, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 25'd1310720, 9'd0, 9'd8, 60, 1'b1);
    run_phase(1'b0, 32'sd0, 32'sd0, 16'sd16384, 16'sd0, 25'd1310720, 9'd16, 9'd16, 80, 1'b1);
    run_phase(1'b1, 32'sh80000000, 32'sh7FFFFFFF, 16'sd16384, -16'sd16384, 25'd65536, 9'd32,
              9'd32, 120, 1'b1);
    run_phase(1'b1, 32'($urandom_range(0, 131072)) - 32'sd65536,
              32'($urandom_range(0, 131072)) - 32'sd65536, -16'sd16384, 16'sd16384,
              25'd2621440, 9'd20, 9'd20, 120, 1'b1);
    // closing stretch without gaps
    run_phase(1'b1, 32'sd3277, -32'sd3277, q14($cos(-0.7)), q14($sin(-0.7)), 25'd1310720,
              9'd12, 9'd12, 120, 1'b0);

    $display("Covered %0d grid loads and %0d cell transfers over %0d register settings;",
             loads_sent, cells_sent, settings_used);
    $display("%0d results compared, %0d of them cost writes.", results_seen, writes_seen);
    if (fail_count == 0) begin
      $display("RESULT: OK");
    end else begin
      $display("RESULT: ERROR");
    end
    $finish;
  end

endmodule
